### rtl/csvt_pkg.sv
// csvt_pkg: shared types and constants for the csv byte tokenizer
// no dependencies; imported by every module of the block

package csvt_pkg;

  localparam logic [7:0] QUOTE_BYTE    = 8'h22;
  localparam logic [7:0] CR_BYTE       = 8'h0D;
  localparam logic [7:0] LF_BYTE       = 8'h0A;
  localparam logic [7:0] DEFAULT_DELIM = 8'h2C;

  // token kinds as seen on the result port
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_ROW   = 2'd2;

  // input item actions
  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } token_t;

  // one queue entry: every token that a single input byte produces
  typedef struct packed {
    logic   pair;    // second token is valid
    token_t first;
    token_t second;
  } entry_t;

  // queue fill state as seen by its neighbours
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/csvt_front.sv
// csvt_front: accepts input bytes, keeps the quoting state and builds queue entries
// depends on csvt_pkg

module csvt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic [7:0]          in_byte,
  input  logic [7:0]          field_delimiter,
  input  csvt_pkg::q_status_t q_status,
  output logic                push,
  output csvt_pkg::entry_t    push_entry
);
  import csvt_pkg::*;

  typedef struct packed {
    logic   emit;
    token_t tok;
    logic   in_quotes;
    logic   quote_pending;
    logic   cr_pending;
    logic   row_open;
  } plain_t;

  // one byte with no lookahead pending
  function automatic plain_t plain_byte(input logic [7:0] b, input logic [7:0] delim,
                                        input logic inq);
    plain_t r;
    r = '0;
    r.in_quotes = inq;
    r.row_open  = 1'b1;
    if (inq) begin
      if (b == QUOTE_BYTE) begin
        r.quote_pending = 1'b1;
      end else begin
        r.emit = 1'b1;
        r.tok  = '{kind: KIND_BYTE, data: b};
      end
    end else if (b == QUOTE_BYTE) begin
      r.in_quotes = 1'b1;
    end else if (b == delim) begin
      r.emit = 1'b1;
      r.tok  = '{kind: KIND_FIELD, data: 8'd0};
    end else if (b == CR_BYTE) begin
      r.cr_pending = 1'b1;
    end else if (b == LF_BYTE) begin
      r.emit     = 1'b1;
      r.tok      = '{kind: KIND_ROW, data: 8'd0};
      r.row_open = 1'b0;
    end else begin
      r.emit = 1'b1;
      r.tok  = '{kind: KIND_BYTE, data: b};
    end
    return r;
  endfunction

  logic   in_quotes, quote_pending, cr_pending, row_open;
  logic   in_quotes_next, quote_pending_next, cr_pending_next, row_open_next;
  logic   accept;
  plain_t pb;
  token_t row_tok;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign row_tok  = '{kind: KIND_ROW, data: 8'd0};

  always_comb begin
    in_quotes_next     = in_quotes;
    quote_pending_next = quote_pending;
    cr_pending_next    = cr_pending;
    row_open_next      = row_open;
    push               = 1'b0;
    push_entry         = '0;
    pb                 = plain_byte(in_byte, field_delimiter, in_quotes && !quote_pending);
    priority if (action == ACT_FLUSH) begin
      push               = cr_pending || row_open || quote_pending || in_quotes;
      push_entry.first   = row_tok;
      in_quotes_next     = 1'b0;
      quote_pending_next = 1'b0;
      cr_pending_next    = 1'b0;
      row_open_next      = 1'b0;
    end else if (quote_pending) begin
      if (in_byte == QUOTE_BYTE) begin
        // doubled quote gives one literal quote
        push               = 1'b1;
        push_entry.first   = '{kind: KIND_BYTE, data: QUOTE_BYTE};
        quote_pending_next = 1'b0;
      end else begin
        push               = pb.emit;
        push_entry.first   = pb.tok;
        in_quotes_next     = pb.in_quotes;
        quote_pending_next = pb.quote_pending;
        cr_pending_next    = pb.cr_pending;
        row_open_next      = pb.row_open;
      end
    end else if (cr_pending) begin
      push             = 1'b1;
      push_entry.first = row_tok;
      if (in_byte == LF_BYTE) begin
        cr_pending_next = 1'b0;
        row_open_next   = 1'b0;
      end else begin
        push_entry.pair    = pb.emit;
        push_entry.second  = pb.tok;
        in_quotes_next     = pb.in_quotes;
        quote_pending_next = pb.quote_pending;
        cr_pending_next    = pb.cr_pending;
        row_open_next      = pb.row_open;
      end
    end else begin
      push               = pb.emit;
      push_entry.first   = pb.tok;
      in_quotes_next     = pb.in_quotes;
      quote_pending_next = pb.quote_pending;
      cr_pending_next    = pb.cr_pending;
      row_open_next      = pb.row_open;
    end
    push = push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes     <= 1'b0;
      quote_pending <= 1'b0;
      cr_pending    <= 1'b0;
      row_open      <= 1'b0;
    end else if (accept) begin
      in_quotes     <= in_quotes_next;
      quote_pending <= quote_pending_next;
      cr_pending    <= cr_pending_next;
      row_open      <= row_open_next;
    end
  end

  // a pending quote only exists inside quoting, a pending cr only outside
  a_qp_in_quotes: assert property (@(posedge clk) disable iff (rst)
    quote_pending |-> (in_quotes && !cr_pending))
    else $error("quote pending outside quoting");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_FLUSH) |=>
      !(in_quotes || quote_pending || cr_pending || row_open))
    else $error("flush left state behind");

endmodule

### rtl/csvt_queue.sv
// csvt_queue: short register fifo of token entries between front and back
// depends on csvt_pkg

module csvt_queue #(
  parameter int DEPTH = csvt_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  csvt_pkg::entry_t    push_entry,
  input  logic                pop,
  output csvt_pkg::entry_t    head,
  output csvt_pkg::q_status_t status
);
  import csvt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("pop from empty queue");

endmodule

### rtl/csvt_back.sv
// csvt_back: splits queue entries into single tokens on a registered output
// depends on csvt_pkg

module csvt_back (
  input  logic                clk,
  input  logic                rst,
  input  csvt_pkg::entry_t    head,
  input  csvt_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          token_kind,
  output logic [7:0]          out_byte,
  output logic                last_of_run
);
  import csvt_pkg::*;

  logic   sel;       // second token of the head entry is next
  logic   load;
  logic   take;
  logic   is_last;
  token_t tok;

  assign load    = !out_valid || !out_stall;
  assign take    = load && !q_status.empty;
  assign tok     = sel ? head.second : head.first;
  assign is_last = sel || !head.pair;
  assign pop     = take && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= !q_status.empty;
      if (take) begin
        sel <= !is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      token_kind  <= tok.kind;
      out_byte    <= tok.data;
      last_of_run <= is_last;
    end
  end

  a_sel_pair: assert property (@(posedge clk) disable iff (rst)
    (sel && !q_status.empty) |-> head.pair)
    else $error("second token selected on a single entry");

endmodule

### rtl/csv_byte_tokenizer.sv
// csv_byte_tokenizer: top level of the streaming csv tokenizer
// depends on csvt_pkg, csvt_front, csvt_queue, csvt_back
//
//  channel   handshake                 payload
//  --------  ------------------------  ------------------------------------
//  in        in_valid / in_stall       action, in_byte
//  out       out_valid / out_stall     token_kind, out_byte, last_of_run
//  cfg       cfg_valid / cfg_ready     cfg_data (field delimiter)
//
// one input byte is taken per cycle while the queue has room; each gives up to
// two tokens, and the back end delivers one token per cycle while out_stall is
// low, so the token output port sets the sustained rate. a token passes through
// a queue slot and then the output register on its way from input to output.
// synchronous reset clears the quoting state, the queue and the output
// register, and sets the delimiter to a comma. in_stall is high exactly when
// the queue is full; out_stall holds the output register.

module csv_byte_tokenizer #(
  parameter int QUEUE_DEPTH = csvt_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  // input transactions
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] in_byte,
  // result transactions
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] token_kind,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  // delimiter register writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import csvt_pkg::*;

  logic [7:0] field_delimiter;
  logic       push;
  logic       pop;
  entry_t     push_entry;
  entry_t     head;
  q_status_t  q_status;

  // the register is always writable; the user must write only while the block is idle, it does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_delimiter <= DEFAULT_DELIM;
    end else if (cfg_valid && cfg_ready) begin
      field_delimiter <= cfg_data;
    end
  end

  // front: quoting state machine, one byte per transaction
  csvt_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .in_byte         (in_byte),
    .field_delimiter (field_delimiter),
    .q_status        (q_status),
    .push            (push),
    .push_entry      (push_entry)
  );

  // decoupling queue, one entry per byte that yields any token
  csvt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // back: serialises entries into result transactions
  csvt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_kind  (token_kind),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule
